/* sv/sc2a_pkg.sv */
// Shared types, constants and key tables of the scancode translator.
`timescale 1ns / 1ps

package sc2a_pkg;

   // Character queue: holds at most FIFO_DEPTH-1 characters.
   localparam int FIFO_DEPTH = 128;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);

   // Command queue between the classifier and the executor.
   localparam int CMDQ_DEPTH = 2;
   localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
   localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   localparam int KEY_W = 7;
   localparam int CHAR_W = 8;

   localparam logic [KEY_W-1:0] KEY_ESC   = 7'd1;
   localparam logic [KEY_W-1:0] KEY_CTRL  = 7'd29;
   localparam logic [KEY_W-1:0] KEY_SHIFT = 7'd42;
   localparam logic [KEY_W-1:0] KEY_C     = 7'd46;
   localparam logic [KEY_W-1:0] KEY_ALT   = 7'd56;
   localparam logic [KEY_W-1:0] KEY_CAPS  = 7'd58;
   localparam logic [KEY_W-1:0] KEY_F1    = 7'd59;
   localparam logic [KEY_W-1:0] KEY_F10   = 7'd68;
   localparam logic [KEY_W-1:0] KEY_F11   = 7'd87;
   localparam logic [KEY_W-1:0] KEY_F12   = 7'd88;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_RESET,
      OP_READ
   } op_code_type;

   typedef struct packed {
      op_code_type       code;
      logic [CHAR_W-1:0] ch;
   } op_type;

   localparam logic [CHAR_W-1:0] PLAIN_MAP [128] = '{
      8'hFF, 8'hFE, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
      8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
      8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
      8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'hFD, 8'h61, 8'h73,
      8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
      8'h27, 8'h60, 8'hFC, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
      8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'hFB, 8'h2A,
      8'hFA, 8'h20, 8'hE2, 8'hF9, 8'hF8, 8'hF7, 8'hF6, 8'hF5,
      8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'hF0, 8'hDF, 8'hED, 8'hEC,
      8'hEB, 8'hE7, 8'h2D, 8'hEA, 8'hFF, 8'hE9, 8'h2B, 8'hE5,
      8'hE8, 8'hE6, 8'hE4, 8'hE3, 8'hFF, 8'hFF, 8'hFF, 8'hEF,
      8'hEE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   localparam logic [CHAR_W-1:0] SHIFTED_MAP [128] = '{
      8'hFF, 8'hFE, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
      8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
      8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
      8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'hFD, 8'h41, 8'h53,
      8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
      8'h22, 8'h7E, 8'hFC, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
      8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'hFB, 8'h2A,
      8'hFA, 8'h20, 8'hE2, 8'hF9, 8'hF8, 8'hF7, 8'hF6, 8'hF5,
      8'hF4, 8'hF3, 8'hF2, 8'hF1, 8'hF0, 8'hDF, 8'hED, 8'hEC,
      8'hEB, 8'hE7, 8'h2D, 8'hEA, 8'hFF, 8'hE9, 8'h2B, 8'hE5,
      8'hE8, 8'hE6, 8'hE4, 8'hE3, 8'hFF, 8'hFF, 8'hFF, 8'hEF,
      8'hEE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF
   };

   // Wrapping pointer increment; the depth need not be a power of two.
   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] res;
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = p + PTR_W'(1);
      end
      return res;
   endfunction

endpackage

/* sv/sc2a_if.sv */
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface sc2a_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] scan_byte;

   modport source (output valid, output kind, output scan_byte, input ready);
   modport sink (input valid, input kind, input scan_byte, output ready);
   modport monitor (input valid, input kind, input scan_byte, input ready);
endinterface

interface sc2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_char;
   logic       read_valid;
   logic       fifo_empty;
   logic       reset_request;
   logic       overflow;

   modport source (output valid, output read_char, output read_valid, output fifo_empty,
                   output reset_request, output overflow, input ready);
   modport sink (input valid, input read_char, input read_valid, input fifo_empty,
                 input reset_request, input overflow, output ready);
   modport monitor (input valid, input read_char, input read_valid, input fifo_empty,
                    input reset_request, input overflow, input ready);
endinterface

/* sv/sc2a_front.sv */
// Request classifier: modifier tracking and key table lookup.
`timescale 1ns / 1ps

module sc2a_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_kind,
   input  logic [7:0]            req_scan_byte,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output sc2a_pkg::op_type      cmd_op
);

   logic shift_ff, shift_in;
   logic caps_ff, caps_in;
   logic ctrl_ff, ctrl_in;
   logic accept;
   logic press;
   logic [sc2a_pkg::KEY_W-1:0] key;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;
   assign key       = req_scan_byte[sc2a_pkg::KEY_W-1:0];
   assign press     = !req_scan_byte[7];

   always_comb begin
      shift_in     = shift_ff;
      caps_in      = caps_ff;
      ctrl_in      = ctrl_ff;
      cmd_op.code  = sc2a_pkg::OP_NONE;
      cmd_op.ch    = (shift_ff || caps_ff) ? sc2a_pkg::SHIFTED_MAP[key]
                                           : sc2a_pkg::PLAIN_MAP[key];
      if (req_kind) begin
         cmd_op.code = sc2a_pkg::OP_READ;
      end else if (key inside {sc2a_pkg::KEY_ESC, sc2a_pkg::KEY_ALT,
                               [sc2a_pkg::KEY_F1:sc2a_pkg::KEY_F10],
                               sc2a_pkg::KEY_F11, sc2a_pkg::KEY_F12}) begin
         cmd_op.code = sc2a_pkg::OP_NONE;
      end else if (key == sc2a_pkg::KEY_CTRL) begin
         ctrl_in = press;
      end else if (key == sc2a_pkg::KEY_SHIFT) begin
         shift_in = press;
      end else if (key == sc2a_pkg::KEY_CAPS) begin
         if (press) begin
            caps_in = !caps_ff;
         end
      end else if (press) begin
         if (key == sc2a_pkg::KEY_C && ctrl_ff) begin
            cmd_op.code = sc2a_pkg::OP_RESET;
         end else begin
            cmd_op.code = sc2a_pkg::OP_PUSH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= 1'b0;
         caps_ff  <= 1'b0;
         ctrl_ff  <= 1'b0;
      end else if (accept) begin
         shift_ff <= shift_in;
         caps_ff  <= caps_in;
         ctrl_ff  <= ctrl_in;
      end
   end

endmodule

/* sv/sc2a_queue.sv */
// Two-entry command queue between classifier and executor.
`timescale 1ns / 1ps

module sc2a_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  sc2a_pkg::op_type push_op,
   output logic             pop_valid,
   input  logic             pop_ready,
   output sc2a_pkg::op_type pop_op
);

   sc2a_pkg::op_type entry_ff [sc2a_pkg::CMDQ_DEPTH];
   logic [sc2a_pkg::CMDQ_IDX_W-1:0] wr_idx_ff, rd_idx_ff;
   logic [sc2a_pkg::CMDQ_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = (count_ff != sc2a_pkg::CMDQ_CNT_W'(sc2a_pkg::CMDQ_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_op     = entry_ff[rd_idx_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + sc2a_pkg::CMDQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - sc2a_pkg::CMDQ_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_idx_ff <= wr_idx_ff + sc2a_pkg::CMDQ_IDX_W'(1);
         end
         if (do_pop) begin
            rd_idx_ff <= rd_idx_ff + sc2a_pkg::CMDQ_IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_idx_ff] <= push_op;
      end
   end

endmodule

/* sv/sc2a_back.sv */
// Command executor: character store, pointers and response register.
`timescale 1ns / 1ps

module sc2a_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_ready,
   input  sc2a_pkg::op_type           cmd_op,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [sc2a_pkg::CHAR_W-1:0] rsp_read_char,
   output logic                       rsp_read_valid,
   output logic                       rsp_fifo_empty,
   output logic                       rsp_reset_request,
   output logic                       rsp_overflow
);

   logic [sc2a_pkg::CHAR_W-1:0] char_store_ff [sc2a_pkg::FIFO_DEPTH];
   logic [sc2a_pkg::PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [sc2a_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [sc2a_pkg::PTR_W-1:0] wr_next;
   logic valid_ff;
   logic read_valid_ff, read_valid_in;
   logic empty_ff;
   logic reset_req_ff, reset_req_in;
   logic overflow_ff, overflow_in;
   logic [sc2a_pkg::CHAR_W-1:0] char_ff;
   logic take;
   logic is_empty, is_full;
   logic do_write;

   assign cmd_ready = !valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign wr_next   = sc2a_pkg::ptr_advance(wr_ptr_ff);
   assign is_empty  = (rd_ptr_ff == wr_ptr_ff);
   assign is_full   = (wr_next == rd_ptr_ff);

   always_comb begin
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      read_valid_in = 1'b0;
      reset_req_in  = 1'b0;
      overflow_in   = 1'b0;
      do_write      = 1'b0;
      case (cmd_op.code)
         sc2a_pkg::OP_READ: begin
            if (!is_empty) begin
               read_valid_in = 1'b1;
               rd_ptr_in     = sc2a_pkg::ptr_advance(rd_ptr_ff);
            end
         end
         sc2a_pkg::OP_PUSH: begin
            if (is_full) begin
               overflow_in = 1'b1;
            end else begin
               do_write  = take;
               wr_ptr_in = wr_next;
            end
         end
         sc2a_pkg::OP_RESET: begin
            reset_req_in = 1'b1;
         end
         default: begin
            rd_ptr_in = rd_ptr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         if (take) begin
            valid_ff  <= 1'b1;
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // Store write and registered read share one port each; a command does one or the other.
   always_ff @(posedge clock) begin
      if (do_write) begin
         char_store_ff[wr_ptr_ff] <= cmd_op.ch;
      end
      if (take) begin
         if (read_valid_in) begin
            char_ff <= char_store_ff[rd_ptr_ff];
         end else begin
            char_ff <= '0;
         end
         read_valid_ff <= read_valid_in;
         empty_ff      <= (rd_ptr_in == wr_ptr_in);
         reset_req_ff  <= reset_req_in;
         overflow_ff   <= overflow_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_read_char     = char_ff;
   assign rsp_read_valid    = read_valid_ff;
   assign rsp_fifo_empty    = empty_ff;
   assign rsp_reset_request = reset_req_ff;
   assign rsp_overflow      = overflow_ff;

endmodule

/* sv/scancode_to_ascii_with_fifo.sv */
// Top level of the set-1 scancode to character translator with its character queue.
`timescale 1ns / 1ps
// Path: a request accepted by the front end is registered in a command queue entry and
//   then in the executor's response register before its response reaches the outputs.
// Throughput: one request per cycle while the response side accepts, set by the executor stage.
// Reset (synchronous, active high) clears modifiers, pointers and both queues' control;
//   the character store is not cleared, as only written entries are ever popped.

module scancode_to_ascii_with_fifo (
   input  logic              clock,
   input  logic              reset,
   sc2a_req_if.sink          req_ch,
   sc2a_rsp_if.source        rsp_ch
);

   // Classifier to command queue.
   logic             fq_valid;
   logic             fq_ready;
   sc2a_pkg::op_type fq_op;

   // Command queue to executor.
   logic             qb_valid;
   logic             qb_ready;
   sc2a_pkg::op_type qb_op;

   // The front end tracks Shift, Caps Lock and Ctrl and turns each request into a
   // command: a read, a character push, a reset request, or nothing at all.
   sc2a_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_kind      (req_ch.kind),
      .req_scan_byte (req_ch.scan_byte),
      .cmd_valid     (fq_valid),
      .cmd_ready     (fq_ready),
      .cmd_op        (fq_op)
   );

   // A short queue lets the front end keep taking requests while a response is
   // held up on the output side.
   sc2a_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_op    (fq_op),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_op     (qb_op)
   );

   // The back end owns the character store. A full store drops the new character and
   // flags overflow rather than overwriting the oldest one.
   sc2a_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (qb_valid),
      .cmd_ready         (qb_ready),
      .cmd_op            (qb_op),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_read_char     (rsp_ch.read_char),
      .rsp_read_valid    (rsp_ch.read_valid),
      .rsp_fifo_empty    (rsp_ch.fifo_empty),
      .rsp_reset_request (rsp_ch.reset_request),
      .rsp_overflow      (rsp_ch.overflow)
   );

endmodule

/* sv/sc2a_checker.sv */
// Port-level assertions for the translator, bound to the top level.
`timescale 1ns / 1ps

module sc2a_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_char,
   input logic       rsp_read_valid,
   input logic       rsp_fifo_empty,
   input logic       rsp_reset_request,
   input logic       rsp_overflow
);

   // A response that pops nothing carries a zero character.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_read_valid |-> rsp_read_char == 8'd0)
      else $error("sc2a: non-read response carries a character");

   // Pop, reset request and overflow come from different commands.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_read_valid, rsp_reset_request, rsp_overflow}) <= 1)
      else $error("sc2a: conflicting response flags");

   // An overflow only happens on a full store, which cannot be empty afterwards.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_fifo_empty)
      else $error("sc2a: overflow reported with empty store");

   // A stalled response stays valid and holds its read-valid and empty flags.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_valid)
                                  && $stable(rsp_fifo_empty))
      else $error("sc2a: stalled response changed");

endmodule

bind scancode_to_ascii_with_fifo sc2a_checker u_sc2a_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_read_char     (rsp_ch.read_char),
   .rsp_read_valid    (rsp_ch.read_valid),
   .rsp_fifo_empty    (rsp_ch.fifo_empty),
   .rsp_reset_request (rsp_ch.reset_request),
   .rsp_overflow      (rsp_ch.overflow)
);
